// ===== rtl/ofp_pkg.sv =====
package ofp_pkg;

    localparam int BLOCK_SLOTS_DEF = 16;
    localparam int Q_DEPTH         = 2;
    localparam int N_WORDS         = 6;

    localparam logic [7:0]  TIMEOUT_RESET = 8'd50;
    localparam logic [15:0] W_START       = 16'haa55;
    localparam logic [15:0] W_START_CC    = 16'haa56;
    localparam logic [15:0] W_SWAPPED     = 16'h55aa;
    localparam logic [15:0] W_IDLE        = 16'hffff;

    typedef enum logic [2:0] {
        EV_BLOCK     = 3'd0,
        EV_DONE      = 3'd1,
        EV_DISCARD   = 3'd2,
        EV_SYNC_ZERO = 3'd3,
        EV_TIMEOUT   = 3'd4
    } t_ev_kind;

    // one result, already formatted (unused fields zero)
    typedef struct packed {
        t_ev_kind                      kind;
        logic [N_WORDS-1:0][15:0]      words;   // sig, x, y, w, h, angle
        logic                          cc;
        logic [3:0]                    idx;
        logic [4:0]                    cnt;
    } t_evt;

    typedef struct packed {
        logic valid;
        t_evt evt;
    } t_push;

endpackage

// ===== rtl/ofp_front.sv =====
module ofp_front
    import ofp_pkg::*;
#(
    parameter int BLOCK_SLOTS = BLOCK_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    output t_push       o_push
);

    localparam int CW = $clog2(BLOCK_SLOTS + 1);

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_CHECK  = 2'd1,
        PH_WORDS  = 2'd2,
        PH_TAIL   = 2'd3
    } t_phase;

    t_phase          r_phase, n_phase;
    logic            r_pend, n_pend;
    logic [7:0]      r_low, n_low;
    logic            r_drop, n_drop;
    logic [15:0]     r_prev, n_prev;
    logic [7:0]      r_miss, n_miss;
    logic            r_cc, n_cc;
    logic [15:0]     r_exp, n_exp;
    logic [15:0]     r_sum, n_sum;
    logic [2:0]      r_idx, n_idx;
    logic [CW-1:0]   r_blocks, n_blocks;
    logic            r_lost, n_lost;
    logic [7:0]      r_timeout, n_timeout;
    logic [15:0]     r_words [N_WORDS];

    logic [15:0]     w;
    logic            w_is_start;
    logic [8:0]      miss_inc;
    logic [15:0]     sum_inc;
    logic [2:0]      idx_inc;
    logic [2:0]      need;
    logic            word_wr;
    logic [31:0]     blocks_ext;

    assign w          = {i_byte, r_low};
    assign w_is_start = (w == W_START) || (w == W_START_CC);
    assign miss_inc   = {1'b0, r_miss} + 9'd1;
    assign sum_inc    = r_sum + w;
    assign idx_inc    = r_idx + 3'd1;
    assign need       = r_cc ? 3'd6 : 3'd5;
    assign blocks_ext = 32'(r_blocks);

    always_comb begin
        n_phase   = r_phase;
        n_pend    = r_pend;
        n_low     = r_low;
        n_drop    = r_drop;
        n_prev    = r_prev;
        n_miss    = r_miss;
        n_cc      = r_cc;
        n_exp     = r_exp;
        n_sum     = r_sum;
        n_idx     = r_idx;
        n_blocks  = r_blocks;
        n_lost    = r_lost;
        n_timeout = r_timeout;
        word_wr   = 1'b0;
        o_push    = '0;

        if (i_cfg_wr_en) begin
            n_timeout = i_cfg_wr_data;
        end

        if (i_accept) begin
            if (r_drop) begin
                n_drop = 1'b0;
            end else if (!r_pend) begin
                n_low  = i_byte;
                n_pend = 1'b1;
            end else begin
                n_pend = 1'b0;
                case (r_phase)
                    PH_SEARCH: begin
                        if (w == 16'd0 && r_prev == 16'd0) begin
                            n_lost = 1'b1;
                            n_prev = W_IDLE;
                            n_miss = '0;
                            o_push.valid    = 1'b1;
                            o_push.evt.kind = EV_SYNC_ZERO;
                        end else if (r_prev == W_START && w_is_start) begin
                            n_cc     = (w == W_START_CC);
                            n_blocks = '0;
                            n_phase  = PH_CHECK;
                        end else if (w == W_SWAPPED) begin
                            n_drop = 1'b1;
                            n_prev = w;
                        end else if (miss_inc > {1'b0, r_timeout}) begin
                            n_prev = W_IDLE;
                            n_miss = '0;
                            o_push.valid    = 1'b1;
                            o_push.evt.kind = EV_TIMEOUT;
                        end else begin
                            n_miss = miss_inc[7:0];
                            n_prev = w;
                        end
                    end
                    PH_CHECK: begin
                        if (w_is_start) begin
                            // back-to-back frames: close this one, open the next
                            o_push.valid = 1'b1;
                            if (r_lost) begin
                                n_lost          = 1'b0;
                                o_push.evt.kind = EV_DISCARD;
                            end else begin
                                o_push.evt.kind = EV_DONE;
                                o_push.evt.cnt  = blocks_ext[4:0];
                            end
                            n_cc     = (w == W_START_CC);
                            n_blocks = '0;
                        end else if (w == 16'd0) begin
                            o_push.valid    = 1'b1;
                            o_push.evt.kind = EV_DONE;
                            o_push.evt.cnt  = blocks_ext[4:0];
                            n_phase = PH_SEARCH;
                            n_prev  = W_IDLE;
                            n_miss  = '0;
                        end else begin
                            // frame full: reuse the last slot
                            if (r_blocks >= CW'(BLOCK_SLOTS)) begin
                                n_blocks = CW'(BLOCK_SLOTS - 1);
                            end
                            n_exp   = w;
                            n_sum   = '0;
                            n_idx   = '0;
                            n_phase = PH_WORDS;
                        end
                    end
                    PH_WORDS: begin
                        word_wr = 1'b1;
                        n_sum   = sum_inc;
                        n_idx   = idx_inc;
                        if (idx_inc >= need) begin
                            n_phase = PH_TAIL;
                            if (sum_inc == r_exp) begin
                                o_push.valid    = 1'b1;
                                o_push.evt.kind = EV_BLOCK;
                                for (int i = 0; i < N_WORDS; i++) begin
                                    o_push.evt.words[i] = (3'(i) == r_idx) ? w : r_words[i];
                                end
                                if (!r_cc) begin
                                    o_push.evt.words[N_WORDS-1] = '0;
                                end
                                o_push.evt.cc  = r_cc;
                                o_push.evt.idx = blocks_ext[3:0];
                                n_blocks       = r_blocks + CW'(1);
                            end
                        end
                    end
                    PH_TAIL: begin
                        if (w_is_start) begin
                            n_cc    = (w == W_START_CC);
                            n_phase = PH_CHECK;
                        end else begin
                            o_push.valid    = 1'b1;
                            o_push.evt.kind = EV_DONE;
                            o_push.evt.cnt  = blocks_ext[4:0];
                            n_lost  = 1'b0;
                            n_phase = PH_SEARCH;
                            n_prev  = W_IDLE;
                            n_miss  = '0;
                        end
                    end
                    default: begin
                        n_phase = PH_SEARCH;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEARCH;
            r_pend    <= 1'b0;
            r_low     <= '0;
            r_drop    <= 1'b0;
            r_prev    <= W_IDLE;
            r_miss    <= '0;
            r_cc      <= 1'b0;
            r_exp     <= '0;
            r_sum     <= '0;
            r_idx     <= '0;
            r_blocks  <= '0;
            r_lost    <= 1'b0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            r_phase   <= n_phase;
            r_pend    <= n_pend;
            r_low     <= n_low;
            r_drop    <= n_drop;
            r_prev    <= n_prev;
            r_miss    <= n_miss;
            r_cc      <= n_cc;
            r_exp     <= n_exp;
            r_sum     <= n_sum;
            r_idx     <= n_idx;
            r_blocks  <= n_blocks;
            r_lost    <= n_lost;
            r_timeout <= n_timeout;
        end
    end

    // block word store, no reset: always written before it is read
    always_ff @(posedge i_clk) begin
        if (word_wr && r_idx < 3'(N_WORDS)) begin
            r_words[r_idx] <= w;
        end
    end

endmodule

// ===== rtl/ofp_queue.sv =====
module ofp_queue
    import ofp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_evt  o_head
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_evt          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(Q_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(Q_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.evt;
        end
    end

endmodule

// ===== rtl/ofp_back.sv =====
module ofp_back
    import ofp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_evt         i_q_head,
    output logic         o_pop,
    output logic         o_tvalid,
    input  logic         i_tready,
    output logic [111:0] o_tdata,
    output logic [2:0]   o_tuser
);

    logic r_valid;
    t_evt r_evt;

    assign o_pop    = i_q_valid && (!r_valid || i_tready);
    assign o_tvalid = r_valid;
    assign o_tuser  = r_evt.kind;
    assign o_tdata  = {6'd0, r_evt.cnt, r_evt.idx, r_evt.cc, r_evt.words};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_evt <= i_q_head;
        end
    end

endmodule

// ===== rtl/object_block_frame_parser.sv =====
// Channel   Dir  Handshake            Payload
// s (in)    in   i_s_tvalid/o_s_tready  tdata[7:0] data_byte
// m (out)   out  o_m_tvalid/i_m_tready  tuser event_kind, tdata block fields + count
// cfg       in   i_cfg_wr_en            i_cfg_wr_data sync_timeout_words
//
// One byte per cycle is accepted while the queue is not full. A byte that raises
// an event writes it into the 2-entry request queue at its accepting edge; from
// there it moves to the output register once that is empty or i_m_tready is high.
// Input stalls only when the queue is full: two requests queued behind an
// output register that the master side is holding off. Reset is synchronous,
// active low, and takes effect on the next clock edge; no clearing pass is needed.
module object_block_frame_parser
    import ofp_pkg::*;
#(
    parameter int BLOCK_SLOTS = BLOCK_SLOTS_DEF    // 1..16 block slots per frame
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // byte stream from the camera link
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,      // [7:0] data_byte
    // parsed events
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [111:0] o_m_tdata,      // [15:0] signature, [31:16] x_pos,
                                         // [47:32] y_pos, [63:48] width,
                                         // [79:64] height, [95:80] angle,
                                         // [96] color_code, [100:97] block_index,
                                         // [105:101] block_count, rest zero
    output logic [2:0]   o_m_tuser,      // [2:0] event_kind
    // timeout register
    input  logic         i_cfg_wr_en,
    input  logic [7:0]   i_cfg_wr_data
);

    t_push push;
    logic  q_full;
    logic  q_valid;
    t_evt  q_head;
    logic  q_pop;
    logic  accept;

    // each byte makes at most one request, so one free slot is enough
    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    // front: byte pairing, sync search, frame and checksum tracking
    ofp_front #(
        .BLOCK_SLOTS (BLOCK_SLOTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_byte        (i_s_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (push)
    );

    // decouples the parser from output back-pressure
    ofp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // back: output register, drives the master side
    ofp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_tdata   (o_m_tdata),
        .o_tuser   (o_m_tuser)
    );

endmodule
